// ===== rtl/core/sha512_pkg.sv =====
// package for the sha-512 hash engine: payload types, constants, rotate helper
`default_nettype none
package sha512_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   // command from controller to datapath
   typedef struct packed {
      logic       take_byte;
      logic       pad_write;
      logic [6:0] pad_addr;
      logic       pad_mark;
      logic       pad_zero;
      logic       load_word;
      logic [3:0] load_index;
      logic       start_rounds;
      logic       do_round;
      logic [6:0] round_index;
      logic       fold;
      logic       reset_chain;
      logic [2:0] emit_index;
   } cmd_type;

   typedef struct packed {
      logic [6:0] byte_pos;
   } status_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int LEN_POS = 112;
   localparam int ROUNDS = 80;

   localparam logic [63:0] ROUND_K [0:79] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   localparam logic [63:0] INIT_CHAIN [0:7] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   function automatic logic [63:0] ror64(input logic [63:0] x, input int r);
      ror64 = (x >> r) | (x << (64 - r));
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sha512_ram.sv =====
// generic ram with one write port and one registered read port
`default_nettype none
module sha512_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/sha512_datapath.sv =====
// sha-512 datapath: block store, byte count, schedule, round registers, chain
`default_nettype none
module sha512_datapath
   import sha512_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   input  wire logic [7:0] data_byte,
   output status_type      status,
   output logic [63:0]     digest_word
);
   logic [63:0] cnt_lo_ff, cnt_hi_ff;
   logic [63:0] chain_ff [0:7];
   logic [63:0] v_ff [0:7];
   logic [63:0] w_ff [0:15];
   logic [63:0] lw_ff;        // word being packed from the store
   logic        wr_en;
   logic [6:0]  wr_addr, rd_addr;
   logic [7:0]  wr_data, rd_data;
   logic [63:0] len_hi, len_lo;
   logic [2:0]  loaded_bytes;

   assign status.byte_pos = cnt_lo_ff[6:0];
   assign len_hi = {cnt_hi_ff[60:0], cnt_lo_ff[63:61]};
   assign len_lo = {cnt_lo_ff[60:0], 3'b000};

   always_comb begin
      wr_en = 1'b0;
      wr_addr = cnt_lo_ff[6:0];
      wr_data = data_byte;
      if (cmd.take_byte) begin
         wr_en = 1'b1;
      end else if (cmd.pad_write) begin
         wr_en = 1'b1;
         wr_addr = cmd.pad_addr;
         if (cmd.pad_mark) begin
            wr_data = PAD_BYTE;
         end else if (cmd.pad_zero) begin
            wr_data = 8'h00;
         end else if (cmd.pad_addr[3]) begin
            wr_data = len_lo[8'(7 - cmd.pad_addr[2:0]) * 8 +: 8];
         end else begin
            wr_data = len_hi[8'(7 - cmd.pad_addr[2:0]) * 8 +: 8];
         end
      end
   end

   // load phase reads one byte a cycle; address is word index plus byte count
   assign rd_addr = {cmd.load_index, loaded_bytes};

   sha512_ram #(.WIDTH(8), .DEPTH(128)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // byte counter within the load of one word, plus read-latency tracking
   logic       rd_pend_ff;
   logic [2:0] rd_pos_ff;
   logic [3:0] rd_word_ff;
   always_ff @(posedge clock) begin
      if (reset || !cmd.load_word) begin
         loaded_bytes <= 3'd0;
      end else begin
         loaded_bytes <= loaded_bytes + 3'd1;
      end
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.load_word;
      end
      rd_pos_ff <= loaded_bytes;
      rd_word_ff <= cmd.load_index;
   end

   // round logic
   logic [63:0] wt, a15, a2, g0, g1, s1, ch, s0, mj, x, y, wnew;
   logic [3:0]  ti;
   assign ti = cmd.round_index[3:0];
   assign a15 = w_ff[4'(ti + 4'd1)];
   assign a2 = w_ff[4'(ti + 4'd14)];
   assign g0 = ror64(a15, 1) ^ ror64(a15, 8) ^ (a15 >> 7);
   assign g1 = ror64(a2, 19) ^ ror64(a2, 61) ^ (a2 >> 6);
   assign wnew = w_ff[ti] + g0 + w_ff[4'(ti + 4'd9)] + g1;
   assign wt = (cmd.round_index >= 7'd16) ? wnew : w_ff[ti];
   assign s1 = ror64(v_ff[4], 14) ^ ror64(v_ff[4], 18) ^ ror64(v_ff[4], 41);
   assign ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign x = v_ff[7] + s1 + ch + ROUND_K[cmd.round_index] + wt;
   assign s0 = ror64(v_ff[0], 28) ^ ror64(v_ff[0], 34) ^ ror64(v_ff[0], 39);
   assign mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign y = s0 + mj;

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         lw_ff <= {lw_ff[55:0], rd_data};
         if (rd_pos_ff == 3'd7) begin
            w_ff[rd_word_ff] <= {lw_ff[55:0], rd_data};
         end
      end
      if (cmd.start_rounds) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= chain_ff[i];
      end else if (cmd.do_round) begin
         w_ff[ti] <= wt;
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + x;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= x + y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.reset_chain) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= INIT_CHAIN[i];
         cnt_lo_ff <= 64'd0;
         cnt_hi_ff <= 64'd0;
      end else begin
         if (cmd.fold) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + v_ff[i];
         end
         if (cmd.take_byte) begin
            cnt_lo_ff <= cnt_lo_ff + 64'd1;
            if (cnt_lo_ff == '1) cnt_hi_ff <= cnt_hi_ff + 64'd1;
         end
      end
   end

   assign digest_word = chain_ff[cmd.emit_index];
endmodule
`default_nettype wire

// ===== rtl/core/sha512_ctrl.sv =====
// sha-512 controller: request intake, padding sweep, round sequencing, digest output
`default_nettype none
module sha512_ctrl
   import sha512_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_data,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_index,
   input  wire status_type status,
   output cmd_type         cmd
);
   state_type   state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;      // round / pad address / load word
   logic [2:0]  sub_ff, sub_in;      // byte within word load
   logic        final_ff, final_in;  // compressing the final block
   logic        two_ff, two_in;      // padding needs an extra block
   logic        accept;

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         cnt_ff <= '0;
         sub_ff <= '0;
         final_ff <= 1'b0;
         two_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         sub_ff <= sub_in;
         final_ff <= final_in;
         two_ff <= two_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      sub_in = sub_ff;
      final_in = final_ff;
      two_in = two_ff;
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      rsp_index = cnt_ff[2:0];
      cmd.load_index = cnt_ff[3:0];
      cmd.round_index = cnt_ff;
      cmd.pad_addr = cnt_ff;
      cmd.emit_index = cnt_ff[2:0];
      case (state_ff)
         ST_COLLECT: begin
            req_stall = 1'b0;
            if (accept) begin
               cmd.take_byte = req_data.byte_valid;
               if (req_data.byte_valid && status.byte_pos == 7'h7f) begin
                  // block full: compress, then pad if this also ends the message
                  final_in = 1'b0;
                  two_in = req_data.end_of_message;
                  cnt_in = '0;
                  sub_in = '0;
                  state_in = ST_LOAD;
               end else if (req_data.end_of_message) begin
                  cnt_in = req_data.byte_valid ? 7'(status.byte_pos + 7'd1)
                                               : status.byte_pos;
                  // no room left for the length field behind the pad byte
                  two_in = (cnt_in >= 7'(LEN_POS));
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // sweep from the pad byte or byte 0 to block end; byte_pos marks 0x80
            cmd.pad_write = 1'b1;
            cmd.pad_mark = (cnt_ff == status.byte_pos) &&
                           (two_ff || status.byte_pos < 7'(LEN_POS));
            cmd.pad_zero = !cmd.pad_mark && (cnt_ff < 7'(LEN_POS) || two_ff);
            if (cnt_ff == 7'h7f) begin
               final_in = !two_ff;
               cnt_in = '0;
               sub_in = '0;
               state_in = ST_LOAD;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_LOAD: begin
            cmd.load_word = 1'b1;
            if (sub_ff == 3'd7) begin
               sub_in = '0;
               if (cnt_ff == 7'd15) begin
                  cnt_in = '0;
                  state_in = ST_ROUND;
                  cmd.start_rounds = 1'b0;
               end else begin
                  cnt_in = cnt_ff + 7'd1;
               end
            end else begin
               sub_in = sub_ff + 3'd1;
            end
         end
         ST_ROUND: begin
            // on entry the chain is copied into the working registers
            if (sub_ff == 3'd0) begin
               cmd.start_rounds = 1'b1;
               sub_in = 3'd1;
            end else begin
               cmd.do_round = 1'b1;
               if (cnt_ff == 7'(ROUNDS - 1)) begin
                  state_in = ST_FOLD;
               end else begin
                  cnt_in = cnt_ff + 7'd1;
               end
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            sub_in = '0;
            cnt_in = '0;
            if (final_ff) begin
               state_in = ST_EMIT;
            end else if (two_ff) begin
               // message ended on a block boundary or pad spilled over
               state_in = ST_PAD;
               two_in = 1'b0;
            end else begin
               state_in = ST_COLLECT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (cnt_ff == 7'd7) begin
                  cmd.reset_chain = 1'b1;
                  cnt_in = '0;
                  state_in = ST_COLLECT;
               end else begin
                  cnt_in = cnt_ff + 7'd1;
               end
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/core/sha512_hash_engine.sv =====
// SHA-512 streaming hash engine: top level
// Requests carry one message byte each (byte_valid) and may close the message
// (end_of_message); a bare end request with no byte closes it as it stands.
// One byte is taken per cycle while a block fills. On the 128th byte of a
// block the engine stalls requests for a compression: it packs the block
// from its byte store (one store read port, one byte a cycle), copies the
// chain into the working registers, runs 80 rounds and folds the result into
// the chain. An end request costs a padding sweep of each block it pads plus
// one or two compressions (two when fewer than 17 bytes remain in the block,
// or when the message fills its last block exactly), then eight responses,
// one per cycle while rsp_stall is low. Each response is one 64-bit digest
// word, word 0 first, last_word set on word 7. A stalled response holds; no
// request is taken until all eight are delivered, after which the chaining
// state and byte count are back at their initial values.
// Reset (synchronous, active high) loads the initial hash and clears the count;
// the byte store needs no clearing since every byte is written before use.
`default_nettype none
module sha512_hash_engine
   import sha512_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire logic    req_valid,
   output logic         req_stall,
   output rsp_type      rsp_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall
);
   cmd_type     cmd;
   status_type  status;
   logic [63:0] digest_word;
   logic [2:0]  rsp_index;

   sha512_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_data(req_data), .req_valid(req_valid),
      .req_stall(req_stall), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_index(rsp_index), .status(status), .cmd(cmd)
   );

   sha512_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .data_byte(req_data.data_byte),
      .status(status), .digest_word(digest_word)
   );

   assign rsp_data.digest_word = digest_word;
   assign rsp_data.word_index = rsp_index;
   assign rsp_data.last_word = (rsp_index == 3'd7);

`ifndef ASSERT_OFF
   a_no_take_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken during digest output");
   a_stalled_rsp_holds_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data.word_index))
      else $error("digest word moved under stall");
   a_last_ends_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last_word |=> !rsp_valid)
      else $error("output continued after last word");
`endif
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// self-checking bench for the sha-512 hash engine: digest prediction and scoreboard
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import sha512_pkg::*;

   localparam longint LIMIT = 2000000;

   // running sha-512 state, kept alongside the engine
   class digest_board;
      logic [63:0] chain [8];
      logic [7:0]  blk [128];
      logic [127:0] nbytes;
      rsp_type     pending [$];
      int          errors;

      function void clear_hash();
         for (int i = 0; i < 8; i++) chain[i] = INIT_CHAIN[i];
         nbytes = '0;
      endfunction

      function logic [63:0] rr(logic [63:0] x, int r);
         return (x >> r) | (x << (64 - r));
      endfunction

      function void compress();
         logic [63:0] w [16];
         logic [63:0] v [8];
         logic [63:0] g0, g1, s0, s1, ch, mj, x, y, a15, a2;
         for (int i = 0; i < 16; i++) begin
            w[i] = '0;
            for (int b = 0; b < 8; b++) w[i] = {w[i][55:0], blk[i*8+b]};
         end
         for (int i = 0; i < 8; i++) v[i] = chain[i];
         for (int t = 0; t < 80; t++) begin
            if (t >= 16) begin
               a15 = w[(t-15) & 15];
               a2 = w[(t-2) & 15];
               g0 = rr(a15, 1) ^ rr(a15, 8) ^ (a15 >> 7);
               g1 = rr(a2, 19) ^ rr(a2, 61) ^ (a2 >> 6);
               w[t & 15] = w[t & 15] + g0 + w[(t-7) & 15] + g1;
            end
            s1 = rr(v[4], 14) ^ rr(v[4], 18) ^ rr(v[4], 41);
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            x = v[7] + s1 + ch + ROUND_K[t] + w[t & 15];
            s0 = rr(v[0], 28) ^ rr(v[0], 34) ^ rr(v[0], 39);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            y = s0 + mj;
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + x;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = x + y;
         end
         for (int i = 0; i < 8; i++) chain[i] += v[i];
      endfunction

      function void note_request(req_type r);
         logic [127:0] bits;
         int pos;
         rsp_type e;
         if (r.byte_valid) begin
            blk[nbytes[6:0]] = r.data_byte;
            nbytes++;
            if (nbytes[6:0] == 0) compress();
         end
         if (!r.end_of_message) return;
         bits = nbytes << 3;
         pos = nbytes[6:0];
         blk[pos] = PAD_BYTE;
         pos++;
         if (pos > LEN_POS) begin
            for (; pos < 128; pos++) blk[pos] = '0;
            compress();
            pos = 0;
         end
         for (; pos < LEN_POS; pos++) blk[pos] = '0;
         for (int i = 0; i < 16; i++) blk[LEN_POS+i] = bits[127-8*i -: 8];
         compress();
         for (int i = 0; i < 8; i++) begin
            e.digest_word = chain[i];
            e.word_index = i[2:0];
            e.last_word = (i == 7);
            pending.push_back(e);
         end
         clear_hash();
      endfunction

      function void check_word(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected digest word %h", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.digest_word !== e.digest_word) begin
            $display("%0t digest_word exp %h got %h", $time, e.digest_word, got.digest_word);
            errors++;
         end
         if (got.word_index !== e.word_index) begin
            $display("%0t word_index exp %0d got %0d", $time, e.word_index, got.word_index);
            errors++;
         end
         if (got.last_word !== e.last_word) begin
            $display("%0t last_word exp %0d got %0d", $time, e.last_word, got.last_word);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   req_type req_data = '0;
   logic    req_valid = 1'b0;
   logic    req_stall;
   rsp_type rsp_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;

   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   longint  cycles = 0;
   digest_board board;

   sha512_hash_engine u_dut (
      .clock(clock), .reset(reset),
      .req_data(req_data), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_data(rsp_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) board.check_word(rsp_data);
      if (cycles > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver back-pressure
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // valid stays up past acceptance until the caller or an idle wait drops it
   task automatic send_request(input logic [7:0] b, input logic bv, input logic eom);
      req_type r;
      r.data_byte = b;
      r.byte_valid = bv;
      r.end_of_message = eom;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
      @(negedge clock);
   endtask

   task automatic send_message(input int len, input logic bare_end);
      for (int i = 0; i < len; i++)
         send_request(8'($urandom_range(255)), 1'b1, !bare_end && i == len - 1);
      if (bare_end || len == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   int sent;

   initial begin
      board = new();
      board.clear_hash();
      board.errors = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty message, idle items, single extreme bytes, bare-end message
      send_message(0, 1'b0);
      send_request(8'hff, 1'b0, 1'b0);
      send_request(8'h00, 1'b0, 1'b0);
      send_request(8'h00, 1'b1, 1'b1);
      send_request(8'hff, 1'b1, 1'b1);
      send_request(8'h55, 1'b1, 1'b0);
      send_request(8'haa, 1'b1, 1'b0);
      send_request(8'h3c, 1'b0, 1'b1);

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: send_idle_pct = 20;
            1: send_idle_pct = 71;
            default: send_idle_pct = 0;
         endcase
         recv_idle_pct = (p == 0) ? 71 : (p == 1) ? 20 : 0;
         if (p == 0) begin
            // pad byte lands at 112: length spills into a second block
            send_message(112, 1'b0);
         end else begin
            sent = 0;
            while (sent < 30) begin
               int n;
               logic bare;
               n = $urandom_range(20);
               bare = ($urandom_range(3) == 0);
               // occasional noise between messages
               if ($urandom_range(9) == 0) begin
                  send_request(8'($urandom_range(255)), 1'b0, 1'b0);
                  sent++;
               end
               send_message(n, bare);
               sent += n + ((bare || n == 0) ? 1 : 0);
            end
         end
      end
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire
